// ----- rtl/integer_square_root_defines.svh -----
// Assertion macros used by the checker file.
`ifndef INTEGER_SQUARE_ROOT_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ISR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("isr checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is low.
`define ISR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("isr checker: next-cycle property failed");

`endif

// ----- rtl/isr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package isr_pkg;

  // Root width; the radicand is twice as wide.
  localparam int ROOT_BITS  = 16;
  localparam int RADICAND_W = 2 * ROOT_BITS;
  // Partial remainder never exceeds twice the partial root.
  localparam int REM_W      = ROOT_BITS + 1;
  localparam int CNT_W      = (ROOT_BITS > 2) ? $clog2(ROOT_BITS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_PUBLISH
  } isr_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } isr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last_step;
  } isr_status_t;

endpackage

`default_nettype wire

// ----- rtl/isr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isr_datapath
  import isr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire isr_cmd_t              cmd_i,
  output isr_status_t                status_o,
  input  wire logic [RADICAND_W-1:0] radicand_i,
  output logic      [ROOT_BITS-1:0]  root_o
);

  logic [RADICAND_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_BITS-1:0]  root_q, root_d;
  logic [ROOT_BITS-1:0]  res_q, res_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic [1:0]            pair;
  logic [REM_W:0]        rem_sh;
  logic [REM_W:0]        trial;
  logic [REM_W+1:0]      diff;
  logic                  fits;

  // One root bit per step: bring down two radicand bits, try (root << 2) | 1.
  always_comb begin
    pair   = rad_q[RADICAND_W-1 -: 2];
    rem_sh = {rem_q[ROOT_BITS-1:0], pair};
    trial  = {root_q, 2'b01};
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    fits   = !diff[REM_W+1];
  end

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_BITS - 1);
    end else if (cmd_i.step) begin
      rad_d  = {rad_q[RADICAND_W-3:0], 2'b00};
      rem_d  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_d = {root_q[ROOT_BITS-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
    end
    if (cmd_i.publish) begin
      res_d = root_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign status_o.last_step = (cnt_q == '0);
  assign root_o             = res_q;

endmodule

`default_nettype wire

// ----- rtl/isr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isr_ctrl
  import isr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output isr_cmd_t         cmd_o,
  input  wire isr_status_t status_i
);

  isr_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // Result register can take a new root this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i)         state_d = ST_CALC;
      ST_CALC:    if (status_i.last_step) state_d = ST_PUBLISH;
      ST_PUBLISH: if (out_free)           state_d = ST_IDLE;
      default:                            state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
      end
      ST_PUBLISH: begin
        cmd_o.publish = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/integer_square_root.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Integer square root: each transaction on the input carries an unsigned
// 32-bit radicand and produces one transaction on the output carrying the
// 16-bit floor of its square root (zero gives zero, one gives one). The root
// is built by a restoring digit-by-digit unit that settles one root bit per
// cycle. The radicand is loaded at the edge that accepts it. Then the 16
// iterations of the shared subtract-and-compare step run, one per root bit,
// and a publish step moves the root into the output register. One item is
// in flight at a time. The next is accepted at the earliest in the cycle
// after the root has been published. A new item is accepted even while the
// previous result still waits in the output register; publishing is held
// off only while an earlier result sits there stalled. No state is kept
// between items and there are no configuration registers.

module integer_square_root
  import isr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [RADICAND_W-1:0] radicand_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [ROOT_BITS-1:0]  root_o
);

  isr_cmd_t    cmd;
  isr_status_t status;

  // Sequencer: load, iterate, publish into the output register.
  isr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // Remainder/root registers, iteration counter and result register.
  isr_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .status_o  (status),
    .radicand_i(radicand_i),
    .root_o    (root_o)
  );

endmodule

`default_nettype wire

// ----- rtl/isr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "integer_square_root_defines.svh"

module isr_checker
  import isr_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic [RADICAND_W-1:0] radicand_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [ROOT_BITS-1:0]  root_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result holds.
  `ISR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(root_o))

  // Only one item in flight: input closes right after a transaction.
  `ISR_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_acc, in_stall_o)

  // A result never appears the cycle after acceptance.
  `ISR_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_acc, !$rose(out_valid_o))

  // A new result is published only while the input side is closed.
  `ISR_ASSERT_NOW(a_publish_while_busy, clk_i, rst_ni, $rose(out_valid_o),
                  $past(in_stall_o))

endmodule

bind integer_square_root isr_checker u_isr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .radicand_i (radicand_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .root_o     (root_o)
);

`default_nettype wire
